// ----- sv/chacha_pkg.sv -----
// Shared types, constants and the state-init function of the ChaCha20 stream cipher block.
package chacha_pkg;

	localparam int WORD_W       = 32;
	localparam int BLOCK_WORDS  = 16;
	localparam int BLOCK_BYTES  = 64;
	localparam int POS_W        = $clog2(BLOCK_BYTES);
	localparam int NUM_ROUNDS   = 20;
	localparam int QR_STEPS     = 4;
	localparam int ROUND_CYCLES = NUM_ROUNDS * QR_STEPS;
	localparam int RCNT_W       = $clog2(ROUND_CYCLES);
	localparam int KEY_W        = 256;
	localparam int NONCE_W      = 96;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;

	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_0_7      = 3'd0,
		REG_KEY_8_15     = 3'd1,
		REG_KEY_16_23    = 3'd2,
		REG_KEY_24_31    = 3'd3,
		REG_NONCE_0_7    = 3'd4,
		REG_NONCE_8_11   = 3'd5,
		REG_INIT_COUNTER = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic       load;
		logic       step_en;
		logic [1:0] step;
		logic       diag;
		logic       finalize;
		logic       emit_direct;
		logic       emit_held;
	} dp_cmd_t;

	typedef struct packed {
		logic need_block;
	} dp_status_t;

	function automatic block_t chacha_init(input logic [KEY_W-1:0] key,
		input word_t counter, input logic [NONCE_W-1:0] nonce);
		block_t blk;
		blk[0] = SIGMA_0;
		blk[1] = SIGMA_1;
		blk[2] = SIGMA_2;
		blk[3] = SIGMA_3;
		for (int i = 0; i < 8; i++) begin
			blk[4 + i] = key[WORD_W*i +: WORD_W];
		end
		blk[12] = counter;
		for (int i = 0; i < 3; i++) begin
			blk[13 + i] = nonce[WORD_W*i +: WORD_W];
		end
		return blk;
	endfunction

endpackage

// ----- sv/chacha_ctrl.sv -----
// Controller of the ChaCha20 stream cipher: handshakes and round sequencing.
module chacha_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  chacha_pkg::dp_status_t status,
	output chacha_pkg::dp_cmd_t   cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_EMIT} state_t;

	localparam logic [chacha_pkg::RCNT_W-1:0] LAST_CNT =
		chacha_pkg::RCNT_W'(chacha_pkg::ROUND_CYCLES - 1);

	state_t                      state_q;
	logic [chacha_pkg::RCNT_W-1:0] cnt_q;
	logic                        res_valid_q;
	logic                        out_free;
	logic                        accept;

	always_comb begin
		out_free   = !res_valid_q || !result_stall;
		item_stall = !((state_q == ST_IDLE) && out_free);
		accept     = item_valid && !item_stall;

		cmd             = '0;
		cmd.load        = accept && status.need_block;
		cmd.emit_direct = accept && !status.need_block;
		cmd.step_en     = (state_q == ST_ROUND);
		cmd.step        = cnt_q[1:0];
		cmd.diag        = cnt_q[2];
		cmd.finalize    = (state_q == ST_FINAL);
		cmd.emit_held   = (state_q == ST_EMIT) && out_free;
	end

	assign result_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_direct || cmd.emit_held) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.load) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/chacha_datapath.sv -----
// Datapath of the ChaCha20 stream cipher: config, round state, keystream, output.
module chacha_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [7:0]                         data_in,
	input  logic                               start_message,
	output logic [7:0]                         data_out,
	input  chacha_pkg::dp_cmd_t                cmd,
	output chacha_pkg::dp_status_t             status
);

	logic [chacha_pkg::KEY_W-1:0]   key_q;
	logic [chacha_pkg::NONCE_W-1:0] nonce_q;
	chacha_pkg::word_t              init_ctr_q;
	chacha_pkg::word_t              counter_q;
	logic [chacha_pkg::POS_W-1:0]   pos_q;
	logic                           ks_valid_q;
	chacha_pkg::block_t             w_q;
	chacha_pkg::block_t             ks_q;
	logic [7:0]                     data_q;
	logic [7:0]                     data_out_q;

	chacha_pkg::block_t init_cur;
	chacha_pkg::block_t init_load;
	chacha_pkg::block_t sum_blk;
	chacha_pkg::block_t w_next;
	chacha_pkg::word_t  ks_word;
	chacha_pkg::word_t  ks_shift;
	logic [7:0]         emit_data;
	logic               emit;

	// One step of a quarter round on lane {d, c, b, a}.
	function automatic logic [3:0][31:0] qr_step(input logic [3:0][31:0] v,
		input logic [1:0] st);
		logic [3:0][31:0] r;
		logic [31:0]      sx;
		logic [31:0]      t;
		r = v;
		case (st)
			2'd0: begin
				sx = v[0] + v[1];
				t = v[3] ^ sx;
				r[0] = sx;
				r[3] = {t[15:0], t[31:16]};
			end
			2'd1: begin
				sx = v[2] + v[3];
				t = v[1] ^ sx;
				r[2] = sx;
				r[1] = {t[19:0], t[31:20]};
			end
			2'd2: begin
				sx = v[0] + v[1];
				t = v[3] ^ sx;
				r[0] = sx;
				r[3] = {t[23:0], t[31:24]};
			end
			default: begin
				sx = v[2] + v[3];
				t = v[1] ^ sx;
				r[2] = sx;
				r[1] = {t[24:0], t[31:25]};
			end
		endcase
		return r;
	endfunction

	always_comb begin
		logic [3:0][31:0] lane;
		logic [3:0][31:0] res;
		w_next = w_q;
		for (int l = 0; l < 4; l++) begin
			if (cmd.diag) begin
				lane = {w_q[12 + ((l + 3) & 3)], w_q[8 + ((l + 2) & 3)],
					w_q[4 + ((l + 1) & 3)], w_q[l]};
				res = qr_step(lane, cmd.step);
				w_next[l]                  = res[0];
				w_next[4 + ((l + 1) & 3)]  = res[1];
				w_next[8 + ((l + 2) & 3)]  = res[2];
				w_next[12 + ((l + 3) & 3)] = res[3];
			end else begin
				lane = {w_q[12 + l], w_q[8 + l], w_q[4 + l], w_q[l]};
				res = qr_step(lane, cmd.step);
				w_next[l]      = res[0];
				w_next[4 + l]  = res[1];
				w_next[8 + l]  = res[2];
				w_next[12 + l] = res[3];
			end
		end
	end

	always_comb begin
		init_cur  = chacha_pkg::chacha_init(key_q, counter_q, nonce_q);
		init_load = chacha_pkg::chacha_init(key_q,
			start_message ? init_ctr_q : counter_q, nonce_q);
		for (int i = 0; i < chacha_pkg::BLOCK_WORDS; i++) begin
			sum_blk[i] = w_q[i] + init_cur[i];
		end
		ks_word   = ks_q[pos_q[5:2]];
		ks_shift  = ks_word >> {pos_q[1:0], 3'b000};
		emit_data = cmd.emit_held ? data_q : data_in;
		emit      = cmd.emit_direct || cmd.emit_held;
		status.need_block = start_message || !ks_valid_q;
	end

	assign data_out = data_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			nonce_q    <= '0;
			init_ctr_q <= '0;
			counter_q  <= '0;
			pos_q      <= '0;
			ks_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					chacha_pkg::REG_KEY_0_7:      key_q[63:0]    <= cfg_data;
					chacha_pkg::REG_KEY_8_15:     key_q[127:64]  <= cfg_data;
					chacha_pkg::REG_KEY_16_23:    key_q[191:128] <= cfg_data;
					chacha_pkg::REG_KEY_24_31:    key_q[255:192] <= cfg_data;
					chacha_pkg::REG_NONCE_0_7:    nonce_q[63:0]  <= cfg_data;
					chacha_pkg::REG_NONCE_8_11:   nonce_q[95:64] <= cfg_data[31:0];
					chacha_pkg::REG_INIT_COUNTER: init_ctr_q     <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.load && start_message) begin
				counter_q <= init_ctr_q;
				pos_q     <= '0;
			end
			if (cmd.finalize) begin
				counter_q  <= counter_q + 1'b1;
				ks_valid_q <= 1'b1;
			end
			if (emit) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == chacha_pkg::POS_W'(chacha_pkg::BLOCK_BYTES - 1)) begin
					ks_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q    <= init_load;
			data_q <= data_in;
		end else if (cmd.step_en) begin
			w_q <= w_next;
		end
		if (cmd.finalize) begin
			ks_q <= sum_blk;
		end
		if (emit) begin
			data_out_q <= emit_data ^ ks_shift[7:0];
		end
	end

endmodule

// ----- sv/chacha20_stream_cipher.sv -----
// Top level of the ChaCha20 stream cipher: one data byte in, one byte out.
// Each accepted byte returns that byte XORed with the next ChaCha20 keystream byte.
// A byte that uses an already generated block leaves in the cycle after acceptance,
// so such bytes stream at one per cycle while the result side takes them. The
// first byte of each 64-byte block, and any byte with start_message set, first
// generates a block: one quarter-round step (add, xor, rotate) on four lanes per
// cycle over all rounds, a feed-forward step, then output once the result side is
// free. Registers must be written through the cfg port only while the block is
// idle; the block does not enforce this, and cfg_ready is always high.
module chacha20_stream_cipher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [7:0]                        data_in,
	input  logic                              start_message,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [7:0]                        data_out
);

	chacha_pkg::dp_cmd_t    cmd;
	chacha_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	chacha_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	chacha_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_in       (data_in),
		.start_message (start_message),
		.data_out      (data_out),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

// ----- sv/chacha_checker.sv -----
// Port-level assertions of the ChaCha20 stream cipher, bound to the top level.
module chacha_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                              item_valid,
	input logic                              item_stall,
	input logic [7:0]                        data_in,
	input logic                              start_message,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic [7:0]                        data_out
);

	logic [1:0] pend_q;
	logic       item_acc;
	logic       res_acc;

	assign item_acc = item_valid && !item_stall;
	assign res_acc  = result_valid && !result_stall;

	// transactions accepted on the item side minus those delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, item_acc} - {1'b0, res_acc};
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(data_out))
		else $error("stalled result changed or dropped");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> pend_q == 2'd1)
		else $error("result delivered without a pending item");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |-> pend_q == 2'd0 || res_acc)
		else $error("item accepted while a result is still owed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind chacha20_stream_cipher chacha_checker u_chk (.*);
